@@ hdl/dpurb_pkg.sv @@
// Shared types and constants for the dual-port UART ring buffer core.
// No dependencies; used by the core and the testbench.
package dpurb_pkg;

  localparam int unsigned RxDepth = 64;
  localparam int unsigned TxDepth = 64;

  localparam int unsigned RxIdxW  = $clog2(RxDepth);
  localparam int unsigned TxIdxW  = $clog2(TxDepth);
  localparam int unsigned RxCntW  = $clog2(RxDepth + 1);
  localparam int unsigned TxCntW  = $clog2(TxDepth + 1);
  localparam int unsigned RxAddrW = $clog2(2 * RxDepth);
  localparam int unsigned TxAddrW = $clog2(2 * TxDepth);

  localparam logic [7:0] LsErrMask    = 8'h0F;
  localparam int unsigned LsRxFullBit  = 5;
  localparam int unsigned LsTxReadyBit = 7;

  typedef enum logic [1:0] {
    FuncRxRead  = 2'd0,
    FuncTxWrite = 2'd1,
    FuncLine    = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StRxEmpty = 2'd1,
    StTxFull  = 2'd2,
    StTxEmpty = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SrcNone = 2'd0,
    SrcRx   = 2'd1,
    SrcTx   = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic [1:0] func;
    logic       port;
    logic [7:0] data_in;
    logic [7:0] line_status;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic       send_valid;
    logic       tx_irq_enable;
    logic       rx_empty;
    logic       tx_full;
    logic       rx_overrun;
    logic       line_error;
  } out_t;

endpackage

@@ hdl/dpurb_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dpurb_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/dual_port_uart_ring_buffers_core.sv @@
// Dual-port UART ring buffer core: rx and tx byte FIFOs for two serial ports.
// Depends on dpurb_pkg and dpurb_ram.
//
// Takes one item per clock while in_stall_o is low and returns exactly one
// result per item, in order. The result is registered and is presented the
// cycle after the input transfer; the byte read from a FIFO comes straight
// out of the RAM's registered read port. Each direction holds both ports'
// rings in one RAM. An item is taken whenever the output register is empty
// or its result is being transferred in the same cycle. Counters and
// pointers reset to zero; the RAMs need no clearing.
module dual_port_uart_ring_buffers_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dpurb_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dpurb_pkg::out_t  out_data_o
);

  logic [dpurb_pkg::RxCntW-1:0] rx_cnt_q [2];
  logic [dpurb_pkg::RxCntW-1:0] rx_cnt_d [2];
  logic [dpurb_pkg::RxIdxW-1:0] rx_wr_q  [2];
  logic [dpurb_pkg::RxIdxW-1:0] rx_wr_d  [2];
  logic [dpurb_pkg::RxIdxW-1:0] rx_rd_q  [2];
  logic [dpurb_pkg::RxIdxW-1:0] rx_rd_d  [2];
  logic [dpurb_pkg::TxCntW-1:0] tx_cnt_q [2];
  logic [dpurb_pkg::TxCntW-1:0] tx_cnt_d [2];
  logic [dpurb_pkg::TxIdxW-1:0] tx_wr_q  [2];
  logic [dpurb_pkg::TxIdxW-1:0] tx_wr_d  [2];
  logic [dpurb_pkg::TxIdxW-1:0] tx_rd_q  [2];
  logic [dpurb_pkg::TxIdxW-1:0] tx_rd_d  [2];
  logic [1:0]                   txint_q;
  logic [1:0]                   txint_d;

  logic                out_valid_q;
  logic                out_valid_d;
  dpurb_pkg::out_t     res_q;
  dpurb_pkg::out_t     res_d;
  dpurb_pkg::rd_src_e  src_q;
  dpurb_pkg::rd_src_e  src_d;

  logic                accept;
  logic                p;
  logic                rx_we;
  logic                rx_re;
  logic                tx_we;
  logic                tx_re;
  logic [dpurb_pkg::RxIdxW-1:0] rx_widx;
  logic [dpurb_pkg::RxIdxW-1:0] rx_ridx;
  logic [dpurb_pkg::TxIdxW-1:0] tx_widx;
  logic [dpurb_pkg::TxIdxW-1:0] tx_ridx;
  logic [dpurb_pkg::RxAddrW-1:0] rx_waddr;
  logic [dpurb_pkg::RxAddrW-1:0] rx_raddr;
  logic [dpurb_pkg::TxAddrW-1:0] tx_waddr;
  logic [dpurb_pkg::TxAddrW-1:0] tx_raddr;
  logic [7:0]          rx_rdata;
  logic [7:0]          tx_rdata;
  logic [dpurb_pkg::RxCntW-1:0] rx_wr_inc;
  logic [dpurb_pkg::RxCntW-1:0] rx_rd_inc;
  logic [dpurb_pkg::TxCntW-1:0] tx_wr_inc;
  logic [dpurb_pkg::TxCntW-1:0] tx_rd_inc;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign p          = in_data_i.port;

  assign rx_widx = rx_wr_q[p];
  assign rx_ridx = rx_rd_q[p];
  assign tx_widx = tx_wr_q[p];
  assign tx_ridx = tx_rd_q[p];

  assign rx_wr_inc = dpurb_pkg::RxCntW'(rx_widx) + 1'b1;
  assign rx_rd_inc = dpurb_pkg::RxCntW'(rx_ridx) + 1'b1;
  assign tx_wr_inc = dpurb_pkg::TxCntW'(tx_widx) + 1'b1;
  assign tx_rd_inc = dpurb_pkg::TxCntW'(tx_ridx) + 1'b1;

  assign rx_waddr = p ? dpurb_pkg::RxAddrW'(dpurb_pkg::RxDepth) + dpurb_pkg::RxAddrW'(rx_widx)
                      : dpurb_pkg::RxAddrW'(rx_widx);
  assign rx_raddr = p ? dpurb_pkg::RxAddrW'(dpurb_pkg::RxDepth) + dpurb_pkg::RxAddrW'(rx_ridx)
                      : dpurb_pkg::RxAddrW'(rx_ridx);
  assign tx_waddr = p ? dpurb_pkg::TxAddrW'(dpurb_pkg::TxDepth) + dpurb_pkg::TxAddrW'(tx_widx)
                      : dpurb_pkg::TxAddrW'(tx_widx);
  assign tx_raddr = p ? dpurb_pkg::TxAddrW'(dpurb_pkg::TxDepth) + dpurb_pkg::TxAddrW'(tx_ridx)
                      : dpurb_pkg::TxAddrW'(tx_ridx);

  always_comb begin
    rx_cnt_d = rx_cnt_q;
    rx_wr_d  = rx_wr_q;
    rx_rd_d  = rx_rd_q;
    tx_cnt_d = tx_cnt_q;
    tx_wr_d  = tx_wr_q;
    tx_rd_d  = tx_rd_q;
    txint_d  = txint_q;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    src_d    = dpurb_pkg::SrcNone;
    res_d    = '0;

    case (in_data_i.func)
      dpurb_pkg::FuncRxRead: begin
        if (rx_cnt_q[p] != '0) begin
          rx_re       = 1'b1;
          src_d       = dpurb_pkg::SrcRx;
          rx_rd_d[p]  = (rx_rd_inc >= dpurb_pkg::RxCntW'(dpurb_pkg::RxDepth)) ? '0
                        : rx_rd_inc[dpurb_pkg::RxIdxW-1:0];
          rx_cnt_d[p] = rx_cnt_q[p] - 1'b1;
        end else begin
          res_d.status = dpurb_pkg::StRxEmpty;
        end
      end
      dpurb_pkg::FuncTxWrite: begin
        if (tx_cnt_q[p] < dpurb_pkg::TxCntW'(dpurb_pkg::TxDepth)) begin
          tx_we       = 1'b1;
          tx_wr_d[p]  = (tx_wr_inc >= dpurb_pkg::TxCntW'(dpurb_pkg::TxDepth)) ? '0
                        : tx_wr_inc[dpurb_pkg::TxIdxW-1:0];
          tx_cnt_d[p] = tx_cnt_q[p] + 1'b1;
          if (tx_cnt_q[p] == '0) begin
            txint_d[p] = 1'b1;
          end
        end else begin
          res_d.status = dpurb_pkg::StTxFull;
        end
      end
      dpurb_pkg::FuncLine: begin
        if ((in_data_i.line_status & dpurb_pkg::LsErrMask) != '0) begin
          res_d.line_error = 1'b1;
        end else if (in_data_i.line_status[dpurb_pkg::LsRxFullBit]) begin
          if (rx_cnt_q[p] < dpurb_pkg::RxCntW'(dpurb_pkg::RxDepth)) begin
            rx_we       = 1'b1;
            rx_wr_d[p]  = (rx_wr_inc >= dpurb_pkg::RxCntW'(dpurb_pkg::RxDepth)) ? '0
                          : rx_wr_inc[dpurb_pkg::RxIdxW-1:0];
            rx_cnt_d[p] = rx_cnt_q[p] + 1'b1;
          end else begin
            res_d.rx_overrun = 1'b1;
          end
        end else if (in_data_i.line_status[dpurb_pkg::LsTxReadyBit]) begin
          if (tx_cnt_q[p] != '0) begin
            tx_re            = 1'b1;
            src_d            = dpurb_pkg::SrcTx;
            res_d.send_valid = 1'b1;
            tx_rd_d[p]       = (tx_rd_inc >= dpurb_pkg::TxCntW'(dpurb_pkg::TxDepth)) ? '0
                               : tx_rd_inc[dpurb_pkg::TxIdxW-1:0];
            tx_cnt_d[p]      = tx_cnt_q[p] - 1'b1;
          end else begin
            res_d.status = dpurb_pkg::StTxEmpty;
            txint_d[p]   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    res_d.tx_irq_enable = txint_d[p];
    res_d.rx_empty      = (rx_cnt_d[p] == '0);
    res_d.tx_full       = (tx_cnt_d[p] >= dpurb_pkg::TxCntW'(dpurb_pkg::TxDepth));
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cnt_q    <= '{default: '0};
      rx_wr_q     <= '{default: '0};
      rx_rd_q     <= '{default: '0};
      tx_cnt_q    <= '{default: '0};
      tx_wr_q     <= '{default: '0};
      tx_rd_q     <= '{default: '0};
      txint_q     <= '0;
      out_valid_q <= 1'b0;
      src_q       <= dpurb_pkg::SrcNone;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        rx_cnt_q <= rx_cnt_d;
        rx_wr_q  <= rx_wr_d;
        rx_rd_q  <= rx_rd_d;
        tx_cnt_q <= tx_cnt_d;
        tx_wr_q  <= tx_wr_d;
        tx_rd_q  <= tx_rd_d;
        txint_q  <= txint_d;
        src_q    <= src_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  dpurb_ram #(
    .Depth (2 * dpurb_pkg::RxDepth),
    .Width (8)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (accept && rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (in_data_i.data_in),
    .re_i    (accept && rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  dpurb_ram #(
    .Depth (2 * dpurb_pkg::TxDepth),
    .Width (8)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (accept && tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (in_data_i.data_in),
    .re_i    (accept && tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  always_comb begin
    out_data_o = res_q;
    case (src_q)
      dpurb_pkg::SrcRx: out_data_o.data_out = rx_rdata;
      dpurb_pkg::SrcTx: out_data_o.data_out = tx_rdata;
      default:          out_data_o.data_out = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // counts never pass the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q[0] <= dpurb_pkg::RxCntW'(dpurb_pkg::RxDepth) &&
    rx_cnt_q[1] <= dpurb_pkg::RxCntW'(dpurb_pkg::RxDepth) &&
    tx_cnt_q[0] <= dpurb_pkg::TxCntW'(dpurb_pkg::TxDepth) &&
    tx_cnt_q[1] <= dpurb_pkg::TxCntW'(dpurb_pkg::TxDepth))
    else $error("ring count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transfer produced no result");

  // an overrun can only happen with a full rx ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rx_overrun |-> !out_data_o.rx_empty)
    else $error("overrun reported with rx ring not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.line_error |->
      !out_data_o.send_valid && out_data_o.data_out == '0 &&
      out_data_o.status == dpurb_pkg::StOk)
    else $error("line error result carries data");

  // a pointer update in port 0 never touches the port 1 pointers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !p |=> $stable(rx_wr_q[1]) && $stable(rx_rd_q[1]) &&
                     $stable(tx_wr_q[1]) && $stable(tx_rd_q[1]))
    else $error("port 0 transfer changed port 1 pointers");

endmodule

@@ tb/dual_port_uart_ring_buffers_core_test.sv @@
// Self-checking testbench for dual_port_uart_ring_buffers_core: both ports' rx/tx byte rings,
// line events, overflow and underflow corners, with random idling and back-pressure.
// Depends on dpurb_pkg and the core RTL.
`timescale 1ns / 1ps

module dual_port_uart_ring_buffers_core_test;

  typedef enum int {
    MixBalanced,
    MixFill,
    MixDrain
  } traffic_mix_e;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  dpurb_pkg::in_t  in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  dpurb_pkg::out_t out_data_o;

  dual_port_uart_ring_buffers_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ring state per port
  logic [7:0] rx_ring [2][dpurb_pkg::RxDepth];
  logic [7:0] tx_ring [2][dpurb_pkg::TxDepth];
  int         rx_fill [2];
  int         rx_head [2];
  int         rx_tail [2];
  int         tx_fill [2];
  int         tx_head [2];
  int         tx_tail [2];
  logic       tx_irq_on [2];

  dpurb_pkg::out_t expected_results_q [$];
  int   error_count;
  int   items_sent;
  int   results_checked;
  int   overruns_seen;
  int   tx_full_seen;
  int   line_errors_seen;
  int   rx_empty_seen;
  int   tx_empty_seen;

  logic sender_idle;
  logic sink_idle;
  int   hold_requests;
  int   hold_request_cycles;

  function automatic dpurb_pkg::out_t uart_ring_step(dpurb_pkg::in_t item);
    dpurb_pkg::out_t r;
    int   p;
    r = '0;
    p = item.port;
    case (dpurb_pkg::func_e'(item.func))
      dpurb_pkg::FuncRxRead: begin
        if (rx_fill[p] > 0) begin
          r.data_out = rx_ring[p][rx_head[p]];
          rx_head[p] = (rx_head[p] + 1) % dpurb_pkg::RxDepth;
          rx_fill[p]--;
        end else begin
          r.status = dpurb_pkg::StRxEmpty;
          rx_empty_seen++;
        end
      end
      dpurb_pkg::FuncTxWrite: begin
        if (tx_fill[p] < dpurb_pkg::TxDepth) begin
          tx_ring[p][tx_tail[p]] = item.data_in;
          tx_tail[p] = (tx_tail[p] + 1) % dpurb_pkg::TxDepth;
          tx_fill[p]++;
          if (tx_fill[p] == 1) tx_irq_on[p] = 1'b1;
        end else begin
          r.status = dpurb_pkg::StTxFull;
          tx_full_seen++;
        end
      end
      dpurb_pkg::FuncLine: begin
        if ((item.line_status & dpurb_pkg::LsErrMask) != 8'h00) begin
          r.line_error = 1'b1;
          line_errors_seen++;
        end else if (item.line_status[dpurb_pkg::LsRxFullBit]) begin
          if (rx_fill[p] < dpurb_pkg::RxDepth) begin
            rx_ring[p][rx_tail[p]] = item.data_in;
            rx_tail[p] = (rx_tail[p] + 1) % dpurb_pkg::RxDepth;
            rx_fill[p]++;
          end else begin
            r.rx_overrun = 1'b1;
            overruns_seen++;
          end
        end else if (item.line_status[dpurb_pkg::LsTxReadyBit]) begin
          if (tx_fill[p] > 0) begin
            r.data_out = tx_ring[p][tx_head[p]];
            r.send_valid = 1'b1;
            tx_head[p] = (tx_head[p] + 1) % dpurb_pkg::TxDepth;
            tx_fill[p]--;
          end else begin
            r.status = dpurb_pkg::StTxEmpty;
            tx_irq_on[p] = 1'b0;
            tx_empty_seen++;
          end
        end
      end
      default: ;
    endcase
    r.tx_irq_enable = tx_irq_on[p];
    r.rx_empty = (rx_fill[p] == 0);
    r.tx_full = (tx_fill[p] >= dpurb_pkg::TxDepth);
    return r;
  endfunction

  task automatic compare_result(dpurb_pkg::out_t want, dpurb_pkg::out_t got);
    if (got !== want) begin
      error_count++;
      if (got.status !== want.status)
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
      if (got.data_out !== want.data_out)
        $display("%0t: data_out expected %02h, got %02h", $time, want.data_out, got.data_out);
      if (got.send_valid !== want.send_valid)
        $display("%0t: send_valid expected %0b, got %0b", $time, want.send_valid,
                 got.send_valid);
      if (got.tx_irq_enable !== want.tx_irq_enable)
        $display("%0t: tx_irq_enable expected %0b, got %0b", $time, want.tx_irq_enable,
                 got.tx_irq_enable);
      if (got.rx_empty !== want.rx_empty)
        $display("%0t: rx_empty expected %0b, got %0b", $time, want.rx_empty, got.rx_empty);
      if (got.tx_full !== want.tx_full)
        $display("%0t: tx_full expected %0b, got %0b", $time, want.tx_full, got.tx_full);
      if (got.rx_overrun !== want.rx_overrun)
        $display("%0t: rx_overrun expected %0b, got %0b", $time, want.rx_overrun,
                 got.rx_overrun);
      if (got.line_error !== want.line_error)
        $display("%0t: line_error expected %0b, got %0b", $time, want.line_error,
                 got.line_error);
    end
  endtask

  // results are checked before the same edge's input transfer is predicted
  always @(posedge clk_i) begin : result_check
    dpurb_pkg::out_t want;
    if (rst_ni === 1'b1) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data_o);
        end else begin
          want = expected_results_q.pop_front();
          compare_result(want, out_data_o);
          results_checked++;
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_results_q.push_back(uart_ring_step(in_data_i));
    end
  end

  initial begin : result_sink
    int burst_left;
    int hold_left;
    int holds_taken;
    burst_left = 0;
    hold_left = 0;
    holds_taken = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_taken) begin
        hold_left = hold_request_cycles;
        holds_taken = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 15) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(dpurb_pkg::in_t item);
    int gap;
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic dpurb_pkg::in_t make_item(dpurb_pkg::func_e f, logic port, logic [7:0] d,
                                               logic [7:0] ls);
    dpurb_pkg::in_t it;
    it.func = f;
    it.port = port;
    it.data_in = d;
    it.line_status = ls;
    return it;
  endfunction

  function automatic dpurb_pkg::in_t make_random_item(traffic_mix_e mix, logic focus);
    int         pick;
    logic       grow;
    logic       port;
    logic [7:0] ls;
    pick = $urandom_range(0, 99);
    port = (mix != MixBalanced && $urandom_range(0, 4) != 0) ? focus : 1'($urandom);
    if (pick < 92) begin
      case (mix)
        MixFill:  grow = (pick < 80);
        MixDrain: grow = (pick >= 80);
        default:  grow = (pick < 46);
      endcase
      if (grow && $urandom_range(0, 1))
        return make_item(dpurb_pkg::FuncLine, port, 8'($urandom),
                         (8'($urandom) & 8'hD0) | 8'h20);
      if (grow)
        return make_item(dpurb_pkg::FuncTxWrite, port, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 1))
        return make_item(dpurb_pkg::FuncRxRead, port, 8'($urandom), 8'($urandom));
      return make_item(dpurb_pkg::FuncLine, port, 8'($urandom),
                       (8'($urandom) & 8'h50) | 8'h80);
    end
    if (pick < 96) begin
      ls = 8'($urandom);
      if ((ls & dpurb_pkg::LsErrMask) == 8'h00) ls[$urandom_range(0, 3)] = 1'b1;
      return make_item(dpurb_pkg::FuncLine, port, 8'($urandom), ls);
    end
    if (pick < 99) return make_item(dpurb_pkg::FuncLine, port, 8'($urandom), 8'($urandom));
    return make_item(dpurb_pkg::FuncNone, port, 8'($urandom), 8'($urandom));
  endfunction

  task automatic test_directed_corners();
    send_item(make_item(dpurb_pkg::FuncRxRead, 1'b0, 8'h00, 8'h00));
    send_item(make_item(dpurb_pkg::FuncRxRead, 1'b1, 8'hFF, 8'hFF));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'h12, 8'h80));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b1, 8'h34, 8'h00));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'h56, 8'h50));
    send_item(make_item(dpurb_pkg::FuncNone, 1'b1, 8'hFF, 8'hFF));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'hAA, 8'h21));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b1, 8'hAA, 8'h82));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'hAA, 8'h04));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b1, 8'hAA, 8'h08));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'h55, 8'hFF));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'h00, 8'h20));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'hFF, 8'hA0));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b1, 8'h5A, 8'h70));
    send_item(make_item(dpurb_pkg::FuncRxRead, 1'b0, 8'h00, 8'h00));
    send_item(make_item(dpurb_pkg::FuncRxRead, 1'b0, 8'h00, 8'h00));
    send_item(make_item(dpurb_pkg::FuncRxRead, 1'b0, 8'h00, 8'h00));
    send_item(make_item(dpurb_pkg::FuncRxRead, 1'b1, 8'h00, 8'h00));
    send_item(make_item(dpurb_pkg::FuncTxWrite, 1'b0, 8'hFF, 8'h00));
    send_item(make_item(dpurb_pkg::FuncTxWrite, 1'b0, 8'h00, 8'h00));
    send_item(make_item(dpurb_pkg::FuncTxWrite, 1'b1, 8'hA5, 8'hFF));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'h00, 8'h80));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'h00, 8'h80));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b0, 8'h00, 8'h80));
    send_item(make_item(dpurb_pkg::FuncLine, 1'b1, 8'h00, 8'hD0));
  endtask

  // push each ring past full, then pop it past empty
  task automatic test_fill_and_drain();
    for (int p = 0; p < 2; p++) begin
      repeat (dpurb_pkg::RxDepth + 2)
        send_item(make_item(dpurb_pkg::FuncLine, 1'(p), 8'($urandom),
                            (8'($urandom) & 8'hD0) | 8'h20));
      repeat (dpurb_pkg::RxDepth + 2)
        send_item(make_item(dpurb_pkg::FuncRxRead, 1'(p), 8'($urandom), 8'($urandom)));
      repeat (dpurb_pkg::TxDepth + 2)
        send_item(make_item(dpurb_pkg::FuncTxWrite, 1'(p), 8'($urandom), 8'($urandom)));
      repeat (dpurb_pkg::TxDepth + 2)
        send_item(make_item(dpurb_pkg::FuncLine, 1'(p), 8'($urandom),
                            (8'($urandom) & 8'h50) | 8'h80));
    end
  endtask

  task automatic test_backpressure();
    sender_idle = 1'b0;
    sink_idle = 1'b0;
    hold_request_cycles = 400;
    hold_requests++;
    repeat (120) send_item(make_random_item(MixBalanced, 1'b0));
  endtask

  task automatic test_random_traffic(int n);
    int           start;
    int           phase_len;
    traffic_mix_e mix;
    logic         focus;
    start = items_sent;
    while (items_sent - start < n) begin
      mix = traffic_mix_e'($urandom_range(0, 2));
      focus = 1'($urandom);
      phase_len = $urandom_range(100, 200);
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      repeat (phase_len) send_item(make_random_item(mix, focus));
    end
  endtask

  task automatic test_no_idle_tail();
    sender_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (150) send_item(make_random_item(MixBalanced, 1'b0));
  endtask

  initial begin : watchdog
    #4_000_000;
    $display("dual_port_uart_ring_buffers_core_test: done, errors");
    $finish;
  end

  initial begin : main
    for (int p = 0; p < 2; p++) begin
      rx_fill[p] = 0;
      rx_head[p] = 0;
      rx_tail[p] = 0;
      tx_fill[p] = 0;
      tx_head[p] = 0;
      tx_tail[p] = 0;
      tx_irq_on[p] = 1'b0;
    end
    error_count = 0;
    items_sent = 0;
    results_checked = 0;
    overruns_seen = 0;
    tx_full_seen = 0;
    line_errors_seen = 0;
    rx_empty_seen = 0;
    tx_empty_seen = 0;
    sender_idle = 1'b1;
    sink_idle = 1'b1;
    hold_requests = 0;
    hold_request_cycles = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_corners();
    test_fill_and_drain();
    test_backpressure();
    test_random_traffic(700);
    test_no_idle_tail();

    in_valid_i <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("covered %0d transfers in, %0d results checked on both ports",
             items_sent, results_checked);
    $display("corners hit: %0d rx overruns, %0d tx full, %0d line errors, %0d/%0d empty pops",
             overruns_seen, tx_full_seen, line_errors_seen, rx_empty_seen, tx_empty_seen);
    if (error_count == 0) begin
      $display("dual_port_uart_ring_buffers_core_test: done, clean");
    end else begin
      $display("dual_port_uart_ring_buffers_core_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/dpurb_pkg.sv
hdl/dpurb_ram.sv
hdl/dual_port_uart_ring_buffers_core.sv
tb/dual_port_uart_ring_buffers_core_test.sv
